FILE: sv/inkwm_pkg.sv
// Shared types and template bit positions for the nozzle waveform merge.
package inkwm_pkg;

  localparam int unsigned STREAMS    = 3;
  localparam int unsigned F3_POS     = 10;
  localparam int unsigned F5_POS     = 11;
  localparam int unsigned CSYNC_LAST = 14;
  localparam int unsigned CSYNC_NORM = 15;
  localparam int unsigned CSYNC_POS  = 3;

  localparam logic [7:0]  NIB_LO    = 8'h0f;
  localparam logic [7:0]  NIB_HI    = 8'hf0;
  localparam logic [15:0] PASS_MASK = 16'hfff0;

  // Item kinds on the input channel.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_MERGE = 1'b1;

  typedef logic [7:0] nozzle_byte_t;

  // Registered read of one packet's nozzle bytes plus the store-empty flag.
  typedef struct packed {
    nozzle_byte_t d1;
    nozzle_byte_t d2;
    nozzle_byte_t d3;
    logic         empty;
  } inkwm_rd_t;

endpackage

FILE: sv/inkwm_store.sv
// Nozzle byte store: three per-stream memories with nonzero flags.
module inkwm_store #(
  parameter int unsigned PACKETS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [5:0]            wr_addr,
  input  logic [7:0]            wr_data,
  input  logic                  rd_en,
  input  logic [3:0]            rd_packet,
  output inkwm_pkg::inkwm_rd_t  rd
);
  import inkwm_pkg::*;

  localparam int unsigned PIW = (PACKETS > 1) ? $clog2(PACKETS) : 1;
  localparam logic [6:0] P1 = 7'(PACKETS);
  localparam logic [6:0] P2 = 7'(2 * PACKETS);
  localparam logic [6:0] P3 = 7'(3 * PACKETS);

  nozzle_byte_t mem0 [PACKETS];
  nozzle_byte_t mem1 [PACKETS];
  nozzle_byte_t mem2 [PACKETS];

  // Flag set means the entry holds a nonzero byte; a clear flag reads as zero.
  logic [PACKETS-1:0] nz0_r, nz1_r, nz2_r;

  logic [6:0]     addr_w;
  logic [6:0]     offs;
  logic [2:0]     sel;
  logic [PIW-1:0] wr_idx;
  logic [PIW-1:0] rd_idx;
  logic           in_range;
  logic           wr_nz;
  nozzle_byte_t   q0, q1, q2;
  logic           v0_r, v1_r, v2_r;
  logic           empty_r;

  always_comb begin
    addr_w = {1'b0, wr_addr};
    sel    = 3'b000;
    offs   = addr_w;
    if (addr_w < P1) begin
      sel = 3'b001;
    end else if (addr_w < P2) begin
      sel  = 3'b010;
      offs = addr_w - P1;
    end else if (addr_w < P3) begin
      sel  = 3'b100;
      offs = addr_w - P2;
    end
  end

  assign wr_idx   = PIW'(offs);
  assign rd_idx   = PIW'(rd_packet);
  assign in_range = ({3'b000, rd_packet} < P1);
  assign wr_nz    = (wr_data != 8'h00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz0_r <= '0;
      nz1_r <= '0;
      nz2_r <= '0;
    end else if (wr_en) begin
      if (sel[0]) nz0_r[wr_idx] <= wr_nz;
      if (sel[1]) nz1_r[wr_idx] <= wr_nz;
      if (sel[2]) nz2_r[wr_idx] <= wr_nz;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && sel[0]) mem0[wr_idx] <= wr_data;
    if (wr_en && sel[1]) mem1[wr_idx] <= wr_data;
    if (wr_en && sel[2]) mem2[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q0 <= mem0[rd_idx];
      q1 <= mem1[rd_idx];
      q2 <= mem2[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      empty_r <= 1'b1;
    end else if (rd_en) begin
      v0_r    <= in_range && nz0_r[rd_idx];
      v1_r    <= in_range && nz1_r[rd_idx];
      v2_r    <= in_range && nz2_r[rd_idx];
      empty_r <= ~(|{nz0_r, nz1_r, nz2_r});
    end
  end

  assign rd.d1    = v0_r ? q0 : 8'h00;
  assign rd.d2    = v1_r ? q1 : 8'h00;
  assign rd.d3    = v2_r ? q2 : 8'h00;
  assign rd.empty = empty_r;

endmodule

FILE: sv/inkjet_nozzle_waveform_merge.sv
// Top level: merges stored nozzle bytes into the drive waveform template.
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  kind, byte_address, byte_value,
//                                         packet_index, packet_start, template_word
//  out_     output     out_valid/out_stall drive_word
//
// One item per cycle while in_stall is low. A load writes the store at its
// accept edge and yields nothing; a template word reads the store at its accept
// edge, is merged in the next cycle against the bit pointer and lands in the
// output register. Reset clears the nonzero flags, pointer and toggle state at
// once. A stalled output holds the merge stage, which stalls input.
module inkjet_nozzle_waveform_merge #(
  parameter int unsigned PACKETS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [5:0]  in_byte_address,
  input  logic [7:0]  in_byte_value,
  input  logic [3:0]  in_packet_index,
  input  logic        in_packet_start,
  input  logic [15:0] in_template_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_drive_word
);
  import inkwm_pkg::*;

  localparam logic [5:0] LAST_PKT = 6'(PACKETS - 1);

  logic        accept;
  logic        adv;
  logic        tmpl_acc;
  inkwm_rd_t   rd;

  logic        a_valid_r, a_valid_nxt;
  logic        a_start_r;
  logic        a_last_r;
  logic [15:0] a_tw_r;

  logic [7:0]  bp_r, bp_nxt;
  logic [1:0]  lt_r, lt_nxt;
  logic        out_valid_r;
  logic [15:0] out_word_r, out_word_nxt;

  logic [7:0]  bp0, bp1;
  logic [1:0]  lt0, tog;
  logic [7:0]  power;
  logic [15:0] v;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = a_valid_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign tmpl_acc = accept && (in_kind == KIND_MERGE);

  inkwm_store #(.PACKETS(PACKETS)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept && (in_kind == KIND_LOAD)),
    .wr_addr   (in_byte_address),
    .wr_data   (in_byte_value),
    .rd_en     (tmpl_acc),
    .rd_packet (in_packet_index),
    .rd        (rd)
  );

  assign a_valid_nxt = tmpl_acc || (a_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tmpl_acc) begin
      a_start_r <= in_packet_start;
      a_last_r  <= ({2'b00, in_packet_index} == LAST_PKT);
      a_tw_r    <= in_template_word;
    end
  end

  // Merge: packet start clears the pointer first; a toggle change advances it.
  always_comb begin
    bp0   = a_start_r ? 8'h00 : bp_r;
    lt0   = a_start_r ? 2'b00 : lt_r;
    tog   = a_tw_r[1:0];
    power = rd.d1 | rd.d2 | rd.d3;
    bp1   = bp0;
    lt_nxt = lt0;
    if (tog != lt0) begin
      bp1    = (bp0 == 8'h00) ? 8'h01 : {bp0[6:0], 1'b0};
      lt_nxt = tog;
    end
    v = a_tw_r & PASS_MASK;
    if ((power & NIB_LO) == 8'h00) v[F3_POS] = 1'b0;
    if ((power & NIB_HI) == 8'h00) v[F5_POS] = 1'b0;
    if (tog != 2'b00) begin
      v[0] = ((rd.d1 & bp1) == 8'h00);
      v[1] = ((rd.d2 & bp1) == 8'h00);
      v[2] = ((rd.d3 & bp1) == 8'h00);
    end
    v[CSYNC_POS] = a_last_r ? a_tw_r[CSYNC_LAST] : a_tw_r[CSYNC_NORM];
    bp_nxt       = bp1;
    out_word_nxt = v;
    if (rd.empty) begin
      // empty store: hold the pointer where packet start left it, drive zero
      bp_nxt       = bp0;
      lt_nxt       = lt0;
      out_word_nxt = 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r        <= 8'h00;
      lt_r        <= 2'b00;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= a_valid_r;
      if (a_valid_r) begin
        bp_r <= bp_nxt;
        lt_r <= lt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive_word = out_word_r;

endmodule

FILE: tb/sv/tb_inkjet_nozzle_waveform_merge.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nozzle waveform merge block.
module tb_inkjet_nozzle_waveform_merge;
  import inkwm_pkg::*;

  localparam int unsigned PACKETS      = 14;
  localparam int unsigned STORE_SIZE   = STREAMS * PACKETS;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned DRAIN_EVERY  = 500;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned FLUSH_CYCLES = 8;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [5:0]  in_byte_address;
  logic [7:0]  in_byte_value;
  logic [3:0]  in_packet_index;
  logic        in_packet_start;
  logic [15:0] in_template_word;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_drive_word;

  // Predicts drive words from the accepted items and checks them in order.
  class merge_chk;
    nozzle_byte_t nozzle_mem [STORE_SIZE];
    logic [7:0]   bit_ptr;
    logic [1:0]   prev_toggle;
    logic [15:0]  pending_words [$];
    int unsigned  mismatches;
    int unsigned  words_checked;
    int unsigned  overflows;
    int unsigned  blank_words;

    function new();
      foreach (nozzle_mem[i]) nozzle_mem[i] = '0;
      bit_ptr       = '0;
      prev_toggle   = '0;
      mismatches    = 0;
      words_checked = 0;
      overflows     = 0;
      blank_words   = 0;
    endfunction

    function bit store_blank();
      foreach (nozzle_mem[i]) if (nozzle_mem[i] != '0) return 1'b0;
      return 1'b1;
    endfunction

    function nozzle_byte_t packet_byte(int unsigned stream, logic [3:0] pkt);
      if (pkt >= PACKETS) return '0;
      return nozzle_mem[stream * PACKETS + pkt];
    endfunction

    function void note_item(logic kind, logic [5:0] addr, nozzle_byte_t value,
                            logic [3:0] pkt, logic start, logic [15:0] tw);
      nozzle_byte_t d1, d2, d3, power;
      logic [15:0]  mask, word;
      logic [1:0]   tog;
      int unsigned  csel;
      if (kind == KIND_LOAD) begin
        if (addr < STORE_SIZE) nozzle_mem[addr] = value;
        return;
      end
      if (start) begin
        bit_ptr     = '0;
        prev_toggle = '0;
      end
      if (store_blank()) begin
        blank_words++;
        pending_words.push_back('0);
        return;
      end
      d1    = packet_byte(0, pkt);
      d2    = packet_byte(1, pkt);
      d3    = packet_byte(2, pkt);
      power = d1 | d2 | d3;
      mask  = PASS_MASK;
      if ((power & NIB_LO) == '0) mask[F3_POS] = 1'b0;
      if ((power & NIB_HI) == '0) mask[F5_POS] = 1'b0;
      csel = (pkt == PACKETS - 1) ? CSYNC_LAST : CSYNC_NORM;
      tog  = tw[1:0];
      // advance the one-hot pointer on any toggle change
      if (tog != prev_toggle) begin
        if (bit_ptr == '0) begin
          bit_ptr = 8'h01;
        end else begin
          if (bit_ptr[7]) overflows++;
          bit_ptr = bit_ptr << 1;
        end
        prev_toggle = tog;
      end
      word = tw & mask;
      if (tog != 2'b00) begin
        word[0] = ((d1 & bit_ptr) == '0);
        word[1] = ((d2 & bit_ptr) == '0);
        word[2] = ((d3 & bit_ptr) == '0);
      end
      if (word[csel]) word[CSYNC_POS] = 1'b1;
      pending_words.push_back(word);
    endfunction

    function void check_drive_word(logic [15:0] got);
      logic [15:0] want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected drive word %h at %0t", got, $realtime);
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: drive_word expected %h actual %h at %0t", want, got, $realtime);
      end
    endfunction
  endclass

  merge_chk    chk;
  int unsigned burst_left;
  int unsigned loads_sent;
  int unsigned merges_sent;
  int unsigned starts_sent;
  int unsigned drains;
  int unsigned idle_cycles;
  int unsigned stall_left;
  stall_mode_e stall_mode;

  inkjet_nozzle_waveform_merge #(
    .PACKETS(PACKETS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_byte_address (in_byte_address),
    .in_byte_value   (in_byte_value),
    .in_packet_index (in_packet_index),
    .in_packet_start (in_packet_start),
    .in_template_word(in_template_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_word  (out_drive_word)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic pause_sender(int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drive_item(logic kind, logic [5:0] addr, nozzle_byte_t value,
                            logic [3:0] pkt, logic start, logic [15:0] tw);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    @(negedge clk);
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_byte_address  <= addr;
    in_byte_value    <= value;
    in_packet_index  <= pkt;
    in_packet_start  <= start;
    in_template_word <= tw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.note_item(kind, addr, value, pkt, start, tw);
    if (kind == KIND_LOAD) begin
      loads_sent++;
    end else begin
      merges_sent++;
      if (start) starts_sent++;
    end
  endtask

  // Hold the sender off until every predicted word has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.pending_words.size() != 0) @(posedge clk);
    drains++;
  endtask

  function automatic nozzle_byte_t pick_nozzle_byte();
    nozzle_byte_t r;
    r = 8'($urandom);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 8'hff;
      2:       return r & NIB_LO;
      3:       return r & NIB_HI;
      default: return r;
    endcase
  endfunction

  function automatic logic [1:0] next_toggle(logic [1:0] cur);
    logic [1:0] t;
    case ($urandom_range(0, 9))
      0:       return cur;
      1:       return 2'b00;
      default: begin
        t = 2'($urandom_range(1, 3));
        if (t == cur) t = (t == 2'd3) ? 2'd1 : t + 2'd1;
        return t;
      end
    endcase
  endfunction

  task automatic load_random_junk(logic [5:0] addr, nozzle_byte_t value);
    logic [15:0] tw;
    tw = 16'($urandom);
    drive_item(KIND_LOAD, addr, value, 4'($urandom_range(0, 15)),
               1'($urandom_range(0, 1)), tw);
  endtask

  task automatic run_packet(logic keep_start);
    logic [3:0]  pkt;
    logic [1:0]  tog;
    logic [15:0] tw;
    int unsigned n;
    if ($urandom_range(0, 9) == 0) pkt = 4'($urandom_range(PACKETS, 15));
    else pkt = 4'($urandom_range(0, PACKETS - 1));
    if ($urandom_range(0, 1) == 1) begin
      for (int s = 0; s < STREAMS; s++) begin
        if ($urandom_range(0, 2) != 0) begin
          if (pkt < PACKETS) load_random_junk(6'(s * PACKETS + pkt), pick_nozzle_byte());
          else load_random_junk(6'($urandom_range(0, 63)), pick_nozzle_byte());
        end
      end
    end
    n   = $urandom_range(4, 20);
    tog = 2'b00;
    for (int i = 0; i < n; i++) begin
      tog = next_toggle(tog);
      tw  = 16'($urandom);
      tw[1:0] = tog;
      drive_item(KIND_MERGE, 6'($urandom_range(0, 63)), 8'($urandom), pkt,
                 (i == 0) && keep_start, tw);
    end
  endtask

  task automatic run_directed();
    logic [1:0] tog;
    drive_item(KIND_MERGE, 6'h00, 8'h00, 4'd0, 1'b1, 16'hffff);
    drive_item(KIND_MERGE, 6'h3f, 8'hff, 4'd13, 1'b0, 16'h0001);
    // out-of-range load addresses leave the store empty
    drive_item(KIND_LOAD, 6'd42, 8'hff, 4'hf, 1'b1, 16'hffff);
    drive_item(KIND_LOAD, 6'h3f, 8'hff, 4'hf, 1'b1, 16'hffff);
    drive_item(KIND_MERGE, 6'h00, 8'h00, 4'd5, 1'b0, 16'hfff3);
    drive_item(KIND_LOAD, 6'd0, 8'h01, 4'h0, 1'b0, 16'h0000);
    drive_item(KIND_LOAD, 6'd14, 8'h80, 4'h0, 1'b0, 16'h0000);
    drive_item(KIND_LOAD, 6'd41, 8'hf0, 4'h0, 1'b0, 16'h0000);
    drive_item(KIND_MERGE, 6'h00, 8'h00, 4'd0, 1'b1, 16'h8000);
    // ten toggle changes walk the pointer off bit 7 and restart it
    for (int i = 0; i < 10; i++) begin
      tog = (i % 2 == 1) ? 2'd2 : 2'd1;
      drive_item(KIND_MERGE, 6'h00, 8'h00, 4'd0, 1'b0, 16'hfff0 | tog);
    end
    drive_item(KIND_MERGE, 6'h00, 8'h00, 4'd13, 1'b1, 16'h4c01);
    drive_item(KIND_MERGE, 6'h00, 8'h00, 4'd13, 1'b0, 16'h8c02);
    drive_item(KIND_MERGE, 6'h00, 8'h00, 4'd14, 1'b1, 16'hffff);
    drive_item(KIND_MERGE, 6'h00, 8'h00, 4'd15, 1'b0, 16'hfffe);
    drive_item(KIND_LOAD, 6'd0, 8'h00, 4'h0, 1'b0, 16'h0000);
    drive_item(KIND_LOAD, 6'd14, 8'h00, 4'h0, 1'b0, 16'h0000);
    drive_item(KIND_LOAD, 6'd41, 8'h00, 4'h0, 1'b0, 16'h0000);
    drive_item(KIND_MERGE, 6'h00, 8'h00, 4'd0, 1'b1, 16'hffff);
  endtask

  // Receiver: pick a new random stall pattern whenever the current one runs out.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_left % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) chk.check_drive_word(out_drive_word);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("ERROR: no item moved for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned target;
    int unsigned next_drain;
    int unsigned choice;
    logic [15:0] tw;
    chk              = new();
    burst_left       = 0;
    loads_sent       = 0;
    merges_sent      = 0;
    starts_sent      = 0;
    drains           = 0;
    idle_cycles      = 0;
    stall_left       = 0;
    stall_mode       = STALL_NONE;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = KIND_LOAD;
    in_byte_address  = '0;
    in_byte_value    = '0;
    in_packet_index  = '0;
    in_packet_start  = 1'b0;
    in_template_word = '0;
    out_stall        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain_results();

    target     = loads_sent + merges_sent + RANDOM_ITEMS;
    next_drain = loads_sent + merges_sent + DRAIN_EVERY;
    while (loads_sent + merges_sent < target) begin
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        run_packet(1'b1);
      end else if (choice < 85) begin
        tw = 16'($urandom);
        drive_item(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), 8'($urandom),
                   4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), tw);
      end else if (choice < 88) begin
        // wipe the store so the empty case comes back
        for (int a = 0; a < STORE_SIZE; a++) load_random_junk(6'(a), '0);
      end else if (choice < 92) begin
        for (int a = 0; a < STORE_SIZE; a++) load_random_junk(6'(a), pick_nozzle_byte());
      end else begin
        run_packet(1'b0);
      end
      if (loads_sent + merges_sent >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
    end

    drain_results();
    repeat (FLUSH_CYCLES) @(posedge clk);
    $display("Run covered %0d loads and %0d template words (%0d packet starts), %0d checked.",
             loads_sent, merges_sent, starts_sent, chk.words_checked);
    $display("Pointer overflows: %0d, words on an empty store: %0d, sender drains: %0d.",
             chk.overflows, chk.blank_words, drains);
    if (chk.mismatches == 0 && chk.pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("ERROR: %0d mismatches, %0d drive words never came",
               chk.mismatches, chk.pending_words.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
